// ===== rtl/atpc_pkg.sv =====
`default_nettype none
package atpc_pkg;

  typedef enum logic [1:0] {
    ACT_SAMPLE    = 2'd0,
    ACT_LOAD      = 2'd1,
    ACT_CLEAR_CH  = 2'd2,
    ACT_CLEAR_ALL = 2'd3
  } action_t;

  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  localparam int CHAN_COUNT = 8;

  localparam logic [11:0] CUTOFF_RESET = 12'd50;
  localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

  // Numerator magnitude: (avg - lm) needs 18 bits signed, (hi - li) 17; product 34 bits.
  localparam int NUM_W = 34;
  localparam int DEN_W = 17;

  typedef struct packed {
    logic [15:0] li;
    logic [15:0] hi;
    logic [15:0] lm;
    logic [15:0] hm;
  } pairs_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/adc_two_point_calibrator.sv =====
// Channel   Ports                          Direction
// in        in_valid, in_stall, in_*       word in
// out       out_valid, out_stall, out_*    word out
// cfg       cfg_we, cfg_wdata              register write
// A sample that completes no average passes ST_READ and ST_EXEC, a command
// these and ST_OUT, a clear of all channels ST_OUT only. An average without
// valid pairs adds ST_AVG and ST_FIN; with pairs the multiply and serial divide too.
// Reset clears the pair valid bits and the per-channel sample counts at once.
// The result waits in an output register, so a stalled result holds the block
// only once the next result is ready to leave.
`default_nettype none
module adc_two_point_calibrator
  import atpc_pkg::*;
#(
  parameter int SAMPLES_PER_RESULT = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [2:0]  in_channel,
  input  wire logic [11:0] in_sample,
  input  wire logic [15:0] in_point_low_ideal,
  input  wire logic [15:0] in_point_high_ideal,
  input  wire logic [15:0] in_point_low_measured,
  input  wire logic [15:0] in_point_high_measured,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [2:0]       out_channel,
  output logic [30:0]      out_value,
  output logic             out_corrected,
  output logic             out_status,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata
);
  localparam int CH_W  = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
  localparam int CNT_W = $clog2(SAMPLES_PER_RESULT + 1);
  localparam int RECIP_SH = 24;
  localparam logic [24:0] RECIP =
    25'((2**RECIP_SH + SAMPLES_PER_RESULT - 1) / SAMPLES_PER_RESULT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_AVG, ST_MUL, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  state_t state_r;
  logic [1:0]  act_r;
  logic [2:0]  ch_r;
  logic [11:0] smp_r;
  pairs_t      ld_r;
  logic [11:0] cutoff_r;
  logic [CHAN_COUNT-1:0] pv_r;
  logic [CHAN_COUNT-1:0] cv_r;
  logic [CH_W-1:0] idx;

  logic pair_we;
  logic [15:0] sum_rdata;
  logic [15+CNT_W:0] sc_wdata, sc_rdata;
  pairs_t pair_rdata, pairs;
  logic [CNT_W-1:0] cnt_rd;

  logic [15:0] sum_r;
  logic signed [17:0] dnum_r;
  logic signed [16:0] dmul_r;
  div_req_t req_r;
  logic start_r;
  logic div_done;
  logic signed [NUM_W:0] quot;
  logic signed [NUM_W+1:0] res_r;
  logic [30:0] oval_r;
  logic okind_r, ocorr_r, ostat_r;
  logic out_load;

  assign idx = ch_r[CH_W-1:0];
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid || !out_stall);

  atpc_ram #(.WIDTH(16 + CNT_W), .DEPTH(CHAN_COUNT)) u_acc (
    .clk(clk), .we(state_r == ST_EXEC && act_r == ACT_SAMPLE),
    .waddr(idx), .wdata(sc_wdata), .raddr(idx), .rdata(sc_rdata)
  );
  atpc_ram #(.WIDTH(64), .DEPTH(CHAN_COUNT)) u_pairs (
    .clk(clk), .we(pair_we), .waddr(idx), .wdata(ld_r), .raddr(idx),
    .rdata(pair_rdata)
  );

  assign pair_we = state_r == ST_EXEC && act_r == ACT_LOAD && ld_r.lm != ld_r.hm;
  assign pairs = pv_r[idx] ? pair_rdata : '0;
  assign cnt_rd = cv_r[idx] ? sc_rdata[CNT_W-1:0] : '0;
  assign sum_rdata = cv_r[idx] ? sc_rdata[15+CNT_W:CNT_W] : 16'd0;

  logic [15:0] sum_new;
  logic last;
  logic pv;
  assign sum_new = sum_rdata + {4'd0, smp_r};
  assign last = (cnt_rd + 1'b1) >= CNT_W'(SAMPLES_PER_RESULT);
  assign sc_wdata = last ? '0 : {sum_new, CNT_W'(cnt_rd + 1'b1)};
  assign pv = (pairs.hm != pairs.lm) && pairs.hm != 0 && pairs.lm != 0 &&
              pairs.hi != 0 && pairs.li != 0;

  logic [40:0] avg_prod;
  logic [15:0] avg_c;
  assign avg_prod = sum_r * RECIP;
  assign avg_c = avg_prod[RECIP_SH+15:RECIP_SH];
  logic signed [NUM_W+1:0] raw_res;
  logic signed [16:0] li_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cutoff_r  <= CUTOFF_RESET;
      pv_r      <= '0;
      cv_r      <= '0;
      start_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start_r <= (state_r == ST_MUL);
      if (cfg_we) cutoff_r <= cfg_wdata;
      if (out_load) begin
        out_valid     <= 1'b1;
        out_kind      <= okind_r;
        out_channel   <= ch_r;
        out_value     <= oval_r;
        out_corrected <= ocorr_r;
        out_status    <= ostat_r;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            act_r <= in_action; ch_r <= in_channel; smp_r <= in_sample;
            ld_r <= '{li: in_point_low_ideal, hi: in_point_high_ideal,
                      lm: in_point_low_measured, hm: in_point_high_measured};
            if (in_action == ACT_CLEAR_ALL) begin
              pv_r <= '0;
              okind_r <= KIND_ACK; oval_r <= '0; ocorr_r <= 1'b0; ostat_r <= 1'b0;
              state_r <= ST_OUT;
            end else if (32'(in_channel) >= CHAN_COUNT) begin
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: state_r <= ST_EXEC;
        ST_EXEC: begin
          oval_r  <= '0;
          ocorr_r <= 1'b0;
          case (act_r)
            ACT_CLEAR_CH: begin
              pv_r[idx] <= 1'b0;
              okind_r <= KIND_ACK;
              ostat_r <= 1'b0;
              state_r <= ST_OUT;
            end
            ACT_LOAD: begin
              if (pair_we) pv_r[idx] <= 1'b1;
              okind_r <= KIND_ACK;
              ostat_r <= (ld_r.lm == ld_r.hm);
              state_r <= ST_OUT;
            end
            default: begin
              cv_r[idx] <= 1'b1;
              okind_r <= KIND_MEAS;
              ostat_r <= 1'b0;
              sum_r <= sum_new;
              state_r <= last ? ST_AVG : ST_IDLE;
            end
          endcase
        end
        ST_AVG: begin
          ocorr_r <= pv;
          dnum_r <= $signed({2'b0, avg_c}) - 18'(signed'(pairs.lm));
          dmul_r <= 17'(signed'(pairs.hi)) - 17'(signed'(pairs.li));
          req_r.den <= 17'(signed'(pairs.hm)) - 17'(signed'(pairs.lm));
          li_r <= 17'(signed'(pairs.li));
          res_r <= $signed({20'd0, avg_c});
          state_r <= pv ? ST_MUL : ST_FIN;
        end
        ST_MUL: begin
          req_r.num <= NUM_W'(dnum_r * dmul_r);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            res_r <= raw_res;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_r > $signed({5'd0, SAT_MAX})) oval_r <= SAT_MAX;
          else if (res_r < $signed({24'd0, cutoff_r})) oval_r <= '0;
          else oval_r <= res_r[30:0];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign raw_res = (NUM_W+2)'(quot) + (NUM_W+2)'(li_r);

  atpc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(start_r), .req(req_r),
    .done(div_done), .quot(quot)
  );

`ifndef SYNTH
  a_hold_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable({out_kind, out_channel, out_corrected, out_status}))
    else $error("stalled word changed");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value))
    else $error("result dropped");
  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_value == 0 && !out_corrected)
    else $error("ack carries value");
`endif
endmodule
`default_nettype wire

// ===== rtl/atpc_ram.sv =====
`default_nettype none
module atpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/atpc_div.sv =====
`default_nettype none
module atpc_div
  import atpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire div_req_t         req,
  output logic                  done,
  output logic signed [NUM_W:0] quot
);
  // Restoring divider on magnitudes, one quotient bit per cycle.
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic             neg_r, neg_nxt;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    if (start) begin
      num_nxt  = req.num[NUM_W-1] ? (~req.num + 1'b1) : req.num;
      den_nxt  = req.den[DEN_W-1] ? (~req.den + 1'b1) : req.den;
      neg_nxt  = req.num[NUM_W-1] ^ req.den[DEN_W-1];
      rem_nxt  = '0;
      q_nxt    = '0;
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb
  import atpc_pkg::*;
();

  typedef struct {
    action_t     act;
    logic [2:0]  ch;
    logic [11:0] smp;
    logic [15:0] li;
    logic [15:0] hi;
    logic [15:0] lm;
    logic [15:0] hm;
  } cal_word_t;

  typedef struct {
    logic        kind;
    logic [2:0]  ch;
    logic [30:0] value;
    logic        corrected;
    logic        status;
  } cal_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [2:0]  in_channel = '0;
  logic [11:0] in_sample = '0;
  logic [15:0] in_point_low_ideal = '0;
  logic [15:0] in_point_high_ideal = '0;
  logic [15:0] in_point_low_measured = '0;
  logic [15:0] in_point_high_measured = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [2:0]  out_channel;
  logic [30:0] out_value;
  logic        out_corrected;
  logic        out_status;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;

  cal_word_t   pending_words[$];
  cal_result_t expected_results[$];
  int          errors = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          corrected_seen = 0;
  bit          calm = 1'b0;
  bit          squeeze = 1'b0;
  int          squeeze_cnt = 0;
  int          send_gap = 0;
  int          recv_gap = 0;

  logic [11:0] cutoff_m;
  logic [15:0] acc_m[8];
  logic [3:0]  cnt_m[8];
  logic [15:0] li_m[8], hi_m[8], lm_m[8], hm_m[8];

  adc_two_point_calibrator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_channel(in_channel), .in_sample(in_sample),
    .in_point_low_ideal(in_point_low_ideal), .in_point_high_ideal(in_point_high_ideal),
    .in_point_low_measured(in_point_low_measured),
    .in_point_high_measured(in_point_high_measured),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_channel(out_channel), .out_value(out_value),
    .out_corrected(out_corrected), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [11:0] rnd12();
    return 12'($urandom);
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic calibrate_word(input cal_word_t w);
    cal_result_t r;
    longint avg, res, li, hi, lm, hm;
    logic [15:0] total;
    bit ok;
    r = '{kind: KIND_ACK, ch: w.ch, value: '0, corrected: 1'b0, status: 1'b0};
    case (w.act)
      ACT_CLEAR_ALL: begin
        for (int c = 0; c < 8; c++) begin
          li_m[c] = '0; hi_m[c] = '0; lm_m[c] = '0; hm_m[c] = '0;
        end
        expected_results.push_back(r);
      end
      ACT_CLEAR_CH: begin
        li_m[w.ch] = '0; hi_m[w.ch] = '0; lm_m[w.ch] = '0; hm_m[w.ch] = '0;
        expected_results.push_back(r);
      end
      ACT_LOAD: begin
        if (w.lm == w.hm) begin
          r.status = 1'b1;
        end else begin
          li_m[w.ch] = w.li; hi_m[w.ch] = w.hi; lm_m[w.ch] = w.lm; hm_m[w.ch] = w.hm;
        end
        expected_results.push_back(r);
      end
      default: begin
        total = acc_m[w.ch] + {4'd0, w.smp};
        if (cnt_m[w.ch] + 1 < 10) begin
          acc_m[w.ch] = total;
          cnt_m[w.ch] = cnt_m[w.ch] + 4'd1;
        end else begin
          acc_m[w.ch] = '0;
          cnt_m[w.ch] = '0;
          avg = longint'(total / 10);
          li = longint'($signed(li_m[w.ch]));
          hi = longint'($signed(hi_m[w.ch]));
          lm = longint'($signed(lm_m[w.ch]));
          hm = longint'($signed(hm_m[w.ch]));
          ok = (hm != lm) && hm != 0 && lm != 0 && hi != 0 && li != 0;
          res = ok ? (avg - lm) * (hi - li) / (hm - lm) + li : avg;
          if (res > 64'sd2147483647) res = 64'sd2147483647;
          if (res < longint'(cutoff_m)) res = 0;
          r.kind = KIND_MEAS;
          r.value = res[30:0];
          r.corrected = ok;
          expected_results.push_back(r);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    cal_word_t w;
    bit taken;
    if (rst_n) begin
      taken = in_valid && !in_stall;
      if (taken) begin
        w = '{act: action_t'(in_action), ch: in_channel, smp: in_sample,
              li: in_point_low_ideal, hi: in_point_high_ideal,
              lm: in_point_low_measured, hm: in_point_high_measured};
        calibrate_word(w);
        words_sent++;
      end
      if (!in_valid || taken) begin
        if (send_gap > 0 && !calm) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_action <= w.act;
          in_channel <= w.ch;
          in_sample <= w.smp;
          in_point_low_ideal <= w.li;
          in_point_high_ideal <= w.hi;
          in_point_low_measured <= w.lm;
          in_point_high_measured <= w.hm;
          in_valid <= 1'b1;
          send_gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (squeeze && squeeze_cnt < 400) begin
        squeeze_cnt <= squeeze_cnt + 1;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cal_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected word, channel", out_channel, -1);
      end else begin
        e = expected_results.pop_front();
        if (out_kind !== e.kind) report("kind", out_kind, e.kind);
        if (out_channel !== e.ch) report("channel", out_channel, e.ch);
        if (out_value !== e.value) report("value", out_value, e.value);
        if (out_corrected !== e.corrected) report("corrected", out_corrected, e.corrected);
        if (out_status !== e.status) report("status", out_status, e.status);
        if (e.corrected) corrected_seen++;
      end
    end
  end

  task automatic add_word(input action_t a, input logic [2:0] c, input logic [11:0] s,
                          input logic [15:0] li, input logic [15:0] hi,
                          input logic [15:0] lm, input logic [15:0] hm);
    pending_words.push_back('{act: a, ch: c, smp: s, li: li, hi: hi, lm: lm, hm: hm});
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_cutoff(input logic [11:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cutoff_m = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_words(input int n);
    int k;
    logic [2:0] c;
    logic [15:0] lm;
    k = 0;
    while (k < n) begin
      c = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1: begin
          lm = 16'($urandom_range(1, 400));
          add_word(ACT_LOAD, c, rnd12(), 16'($urandom_range(1, 300)),
                   16'($urandom_range(3000, 5000)), lm, 16'($urandom_range(3500, 4095)));
          k++;
        end
        2: begin
          add_word(ACT_LOAD, c, rnd12(), rnd16(), rnd16(), rnd16(), rnd16());
          k++;
        end
        3: begin
          lm = rnd16();
          add_word(ACT_LOAD, c, rnd12(), rnd16(), rnd16(), lm,
                   ($urandom_range(0, 1) != 0) ? lm : 16'(lm + 1));
          k++;
        end
        4: begin
          add_word(action_t'($urandom_range(0, 3)), c, rnd12(), rnd16(), rnd16(),
                   rnd16(), rnd16());
          k++;
        end
        default: begin
          for (int i = 0; i < 10; i++) begin
            add_word(ACT_SAMPLE, c, rnd12(), rnd16(), rnd16(), rnd16(), rnd16());
          end
          k += 10;
        end
      endcase
    end
  endtask

  initial begin
    cutoff_m = CUTOFF_RESET;
    for (int c = 0; c < 8; c++) begin
      acc_m[c] = '0; cnt_m[c] = '0;
      li_m[c] = '0; hi_m[c] = '0; lm_m[c] = '0; hm_m[c] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 10; i++) add_word(ACT_SAMPLE, 3'd0, 12'hFFF, '0, '0, '0, '0);
    add_word(ACT_LOAD, 3'd7, '0, 16'h8000, 16'h7FFF, 16'h8000, 16'h8001);
    add_word(ACT_LOAD, 3'd1, '0, 16'h0010, 16'h0020, 16'h1234, 16'h1234);
    add_word(ACT_LOAD, 3'd2, '0, 16'h0000, 16'h0100, 16'h0005, 16'h0FA0);
    add_word(ACT_LOAD, 3'd3, '0, 16'hFF00, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    for (int i = 0; i < 10; i++) add_word(ACT_SAMPLE, 3'd7, 12'hFFF, '0, '0, '0, '0);
    add_word(ACT_CLEAR_CH, 3'd7, '0, '0, '0, '0, '0);
    add_word(ACT_CLEAR_ALL, 3'd5, '0, '0, '0, '0, '0);
    drain();

    set_cutoff(12'd0);
    for (int i = 0; i < 10; i++) add_word(ACT_SAMPLE, 3'd4, 12'h000, '0, '0, '0, '0);
    random_words(400);
    drain();

    set_cutoff(12'hFFF);
    squeeze = 1'b1;
    random_words(400);
    drain();

    set_cutoff(12'($urandom));
    random_words(400);
    drain();

    set_cutoff(CUTOFF_RESET);
    calm = 1'b1;
    random_words(400);
    drain();

    $display("sent %0d words, checked %0d results, %0d of them interpolated",
             words_sent, results_seen, corrected_seen);
    $display("cutoff settings covered reset value, zero, maximum and random");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS adc_two_point_calibrator");
    end else begin
      $display("FAIL adc_two_point_calibrator");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL adc_two_point_calibrator");
    $finish;
  end

endmodule
